>>> hdl/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants for the one-wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

    localparam int unsigned REG_W    = 10;
    localparam int unsigned NUM_REGS = 7;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CMP_W    = 16;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_BIT   = 2'd2;
    localparam logic [1:0] CMD_BYTE  = 2'd3;

    localparam logic [2:0] REG_RLOW   = 3'd0;
    localparam logic [2:0] REG_SETTLE = 3'd1;
    localparam logic [2:0] REG_TMO    = 3'd2;
    localparam logic [2:0] REG_SLOW   = 3'd3;
    localparam logic [2:0] REG_SDLY   = 3'd4;
    localparam logic [2:0] REG_REST   = 3'd5;
    localparam logic [2:0] REG_RECV   = 3'd6;

    localparam logic [REG_W-1:0] RST_RLOW   = 10'd500;
    localparam logic [REG_W-1:0] RST_SETTLE = 10'd10;
    localparam logic [REG_W-1:0] RST_TMO    = 10'd250;
    localparam logic [REG_W-1:0] RST_SLOW   = 10'd1;
    localparam logic [REG_W-1:0] RST_SDLY   = 10'd13;
    localparam logic [REG_W-1:0] RST_REST   = 10'd46;
    localparam logic [REG_W-1:0] RST_RECV   = 10'd1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RLOW,
        PH_RSET,
        PH_PLOW,
        PH_PHIGH,
        PH_SLOW,
        PH_SDLY,
        PH_SAMP,
        PH_REST,
        PH_RECV
    } t_phase;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] tx_byte;
        logic       line_level;
    } t_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_byte;
    } t_out;

    typedef struct packed {
        logic [REG_W-1:0] reset_low_time;
        logic [REG_W-1:0] presence_settle_time;
        logic [REG_W-1:0] presence_timeout;
        logic [REG_W-1:0] slot_low_time;
        logic [REG_W-1:0] sample_delay;
        logic [REG_W-1:0] slot_rest_time;
        logic [REG_W-1:0] recovery_time;
    } t_cfg;

endpackage

>>> hdl/owb_cfg.sv
// ----------------------------------------------------------------------------
// owb_cfg
// Timing register file behind an APB-style port.
// ----------------------------------------------------------------------------
module owb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owb_pkg::ADDR_W-1:0]    paddr,
    input  logic [owb_pkg::DATA_W-1:0]    pwdata,
    output logic [owb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output owb_pkg::t_cfg                 o_cfg
);
    import owb_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] idx;
    logic       wr_en;
    logic [REG_W-1:0] rd_val;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_RLOW:   n_cfg.reset_low_time       = pwdata[REG_W-1:0];
                REG_SETTLE: n_cfg.presence_settle_time = pwdata[REG_W-1:0];
                REG_TMO:    n_cfg.presence_timeout     = pwdata[REG_W-1:0];
                REG_SLOW:   n_cfg.slot_low_time        = pwdata[REG_W-1:0];
                REG_SDLY:   n_cfg.sample_delay         = pwdata[REG_W-1:0];
                REG_REST:   n_cfg.slot_rest_time       = pwdata[REG_W-1:0];
                REG_RECV:   n_cfg.recovery_time        = pwdata[REG_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_RLOW:   rd_val = r_cfg.reset_low_time;
            REG_SETTLE: rd_val = r_cfg.presence_settle_time;
            REG_TMO:    rd_val = r_cfg.presence_timeout;
            REG_SLOW:   rd_val = r_cfg.slot_low_time;
            REG_SDLY:   rd_val = r_cfg.sample_delay;
            REG_REST:   rd_val = r_cfg.slot_rest_time;
            REG_RECV:   rd_val = r_cfg.recovery_time;
            default:    rd_val = '0;
        endcase
    end

    assign prdata = DATA_W'(rd_val);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time       <= RST_RLOW;
            r_cfg.presence_settle_time <= RST_SETTLE;
            r_cfg.presence_timeout     <= RST_TMO;
            r_cfg.slot_low_time        <= RST_SLOW;
            r_cfg.sample_delay         <= RST_SDLY;
            r_cfg.slot_rest_time       <= RST_REST;
            r_cfg.recovery_time        <= RST_RECV;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> hdl/owb_core.sv
// ----------------------------------------------------------------------------
// owb_core
// Bus sequencer: advances reset and time-slot phases one tick per step.
// ----------------------------------------------------------------------------
module owb_core #(
    parameter int unsigned COUNT_WIDTH = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  owb_pkg::t_in  i_in,
    input  owb_pkg::t_cfg i_cfg,
    output owb_pkg::t_out o_res
);
    import owb_pkg::*;

    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((32'd1 << COUNT_WIDTH) - 32'd1);

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_kind, n_kind;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [2:0]             r_slot, n_slot;
    logic [7:0]             r_sr, n_sr;
    logic                   r_pres_seen, n_pres_seen;
    logic                   r_tx_bit, n_tx_bit;

    logic [REG_W-1:0]       lim_sel;
    logic [CMP_W-1:0]       lim_ext;
    logic [CMP_W-1:0]       lim;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   hit;
    logic                   end_slot;
    logic                   finish;
    logic                   finish_ok;
    t_out                   res;

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_count     = r_count;
        n_slot      = r_slot;
        n_sr        = r_sr;
        n_pres_seen = r_pres_seen;
        n_tx_bit    = r_tx_bit;
        res         = '0;
        end_slot    = 1'b0;
        finish      = 1'b0;
        finish_ok   = 1'b0;

        if (r_phase == PH_IDLE && i_in.command != CMD_TICK) begin
            n_kind  = i_in.command;
            n_slot  = '0;
            n_count = '0;
            if (i_in.command == CMD_RESET) begin
                n_pres_seen = 1'b0;
                n_phase     = PH_RLOW;
            end else begin
                n_sr     = (i_in.command == CMD_BIT) ? {7'd0, i_in.tx_byte[0]}
                                                     : i_in.tx_byte;
                n_tx_bit = n_sr[0];
                n_phase  = PH_SLOW;
            end
        end

        case (n_phase)
            PH_RLOW:             lim_sel = i_cfg.reset_low_time;
            PH_RSET:             lim_sel = i_cfg.presence_settle_time;
            PH_PLOW, PH_PHIGH:   lim_sel = i_cfg.presence_timeout;
            PH_SLOW:             lim_sel = i_cfg.slot_low_time;
            PH_SDLY:             lim_sel = i_cfg.sample_delay;
            PH_REST:             lim_sel = i_cfg.slot_rest_time;
            PH_RECV:             lim_sel = i_cfg.recovery_time;
            default:             lim_sel = '0;
        endcase
        lim_ext = CMP_W'(lim_sel);
        lim     = (lim_ext > CNT_MAX) ? CNT_MAX : lim_ext;
        cnt_inc = n_count + 1'b1;
        cnt_ext = CMP_W'(cnt_inc);
        hit     = (cnt_ext >= lim);

        unique case (n_phase)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_RLOW: begin
                res.drive_low = 1'b1;
                n_count       = cnt_inc;
                if (hit) begin
                    n_phase = (i_cfg.presence_settle_time != '0) ? PH_RSET : PH_PLOW;
                    n_count = '0;
                end
            end
            PH_RSET: begin
                n_count = cnt_inc;
                if (hit) begin
                    n_phase = PH_PLOW;
                    n_count = '0;
                end
            end
            PH_PLOW: begin
                if (!i_in.line_level) begin
                    n_phase = PH_PHIGH;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc;
                    finish  = hit;
                end
            end
            PH_PHIGH: begin
                if (i_in.line_level) begin
                    finish    = 1'b1;
                    finish_ok = 1'b1;
                end else begin
                    n_count = cnt_inc;
                    finish  = hit;
                end
            end
            PH_SLOW: begin
                res.drive_low = 1'b1;
                n_count       = cnt_inc;
                if (hit) begin
                    n_phase = (i_cfg.sample_delay != '0) ? PH_SDLY : PH_SAMP;
                    n_count = '0;
                end
            end
            PH_SDLY: begin
                res.drive_low = ~n_tx_bit;
                n_count       = cnt_inc;
                if (hit) begin
                    n_phase = PH_SAMP;
                    n_count = '0;
                end
            end
            PH_SAMP: begin
                res.drive_low = ~n_tx_bit;
                n_sr          = {i_in.line_level, n_sr[7:1]};
                n_count       = '0;
                if (i_cfg.slot_rest_time != '0) begin
                    n_phase = PH_REST;
                end else if (i_cfg.recovery_time != '0) begin
                    n_phase = PH_RECV;
                end else begin
                    end_slot = 1'b1;
                end
            end
            PH_REST: begin
                res.drive_low = ~n_tx_bit;
                n_count       = cnt_inc;
                if (hit) begin
                    n_count = '0;
                    if (i_cfg.recovery_time != '0) begin
                        n_phase = PH_RECV;
                    end else begin
                        end_slot = 1'b1;
                    end
                end
            end
            PH_RECV: begin
                n_count = cnt_inc;
                if (hit) begin
                    n_count  = '0;
                    end_slot = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (finish) begin
            n_pres_seen  = finish_ok;
            res.done_res = 1'b1;
            res.presence = finish_ok;
            n_phase      = PH_IDLE;
            n_count      = '0;
        end

        if (end_slot) begin
            n_count = '0;
            if (n_kind == CMD_BIT) begin
                res.done_res = 1'b1;
                res.rx_byte  = {7'd0, n_sr[7]};
                n_phase      = PH_IDLE;
            end else if (n_slot == 3'd7) begin
                res.done_res = 1'b1;
                res.rx_byte  = n_sr;
                n_slot       = '0;
                n_phase      = PH_IDLE;
            end else begin
                n_slot   = n_slot + 3'd1;
                n_tx_bit = n_sr[0];
                n_phase  = PH_SLOW;
            end
        end

        res.busy_res = (n_phase != PH_IDLE);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_kind      <= CMD_TICK;
            r_count     <= '0;
            r_slot      <= '0;
            r_sr        <= '0;
            r_pres_seen <= 1'b0;
            r_tx_bit    <= 1'b0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_count     <= n_count;
            r_slot      <= n_slot;
            r_sr        <= n_sr;
            r_pres_seen <= n_pres_seen;
            r_tx_bit    <= n_tx_bit;
        end
    end

endmodule

>>> hdl/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// One-wire bus master: reset/presence and read/write time slots, one tick
// per transaction.
//
//   channel   direction  signals                              payload
//   in        input      i_in_valid / o_in_stall              i_in_data  (t_in)
//   out       output     o_out_valid / i_out_stall            o_out_data (t_out)
//   config    input      psel penable pwrite paddr pwdata     prdata, pready
//
// One transaction per clock sustained while the output is not stalled; each result is
// presented after its tick is accepted (input register, then result register).
// The sequencer step lies between the two registers.
// Synchronous active-low reset returns the sequencer to idle and the timing
// registers to their defaults. A stalled output holds the result register and
// then the input register; the sequencer advances only when a result can move.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit #(
    parameter int unsigned COUNT_WIDTH = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  owb_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output owb_pkg::t_out                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owb_pkg::ADDR_W-1:0]    paddr,
    input  logic [owb_pkg::DATA_W-1:0]    pwdata,
    output logic [owb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import owb_pkg::*;

    t_cfg cfg;
    t_in  r_in;
    logic r_in_valid;
    t_out r_out;
    logic r_out_valid;
    t_out res;
    logic advance;
    logic step;

    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    owb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    owb_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_in    (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> test/tb_one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master_unit
// Self-checking testbench for the one-wire bus master. Microsecond ticks are
// sent in random bursts while the result side stalls on its own pattern. A
// cycle-level model of the reset/presence and time-slot sequencer predicts
// every result, and each result is compared field by field in arrival order.
// Timing registers are written over the APB port while no result is pending,
// with extreme, zero and mid-operation values; extreme and zero are read back.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master_unit;

    import owb_pkg::*;

    localparam int unsigned COUNT_WIDTH = 10;
    localparam int unsigned UNUSED_REG  = NUM_REGS;
    localparam int unsigned CYCLE_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in                i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out               o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    one_wire_bus_master_unit #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    // sequencer model state
    t_phase                 seq_phase;
    logic [1:0]             op_kind;
    logic [COUNT_WIDTH-1:0] us_count;
    logic [2:0]             slot_idx;
    logic [7:0]             rx_shift;
    logic                   pres_seen;
    logic                   tx_bit;
    t_cfg                   timing;
    t_out                   tick_res;

    t_out        pending_results[$];
    int unsigned err_count;
    int unsigned results_seen;
    int unsigned cycles;
    int unsigned burst_left;
    bit          gaps_on;
    int unsigned stall_pct;
    int unsigned stall_left;

    function automatic void enter(t_phase p);
        seq_phase = p;
        us_count  = '0;
    endfunction

    function automatic logic count_done(logic [REG_W-1:0] lim);
        us_count = us_count + 1'b1;
        return us_count >= lim;
    endfunction

    function automatic void begin_slot();
        tx_bit = rx_shift[0];
        enter(PH_SLOW);
    endfunction

    function automatic void finish_reset(logic ok);
        pres_seen         = ok;
        tick_res.done_res = 1'b1;
        tick_res.presence = ok;
        enter(PH_IDLE);
    endfunction

    function automatic void close_slot();
        if (op_kind == CMD_BIT) begin
            tick_res.done_res = 1'b1;
            tick_res.rx_byte  = {7'd0, rx_shift[7]};
            enter(PH_IDLE);
        end else if (slot_idx == 3'd7) begin
            tick_res.done_res = 1'b1;
            tick_res.rx_byte  = rx_shift;
            slot_idx          = '0;
            enter(PH_IDLE);
        end else begin
            slot_idx = slot_idx + 1'b1;
            begin_slot();
        end
    endfunction

    function automatic void after_rest();
        if (timing.recovery_time != '0) begin
            enter(PH_RECV);
        end else begin
            close_slot();
        end
    endfunction

    function automatic t_out bus_tick(t_in it);
        tick_res = '0;
        if (seq_phase == PH_IDLE && it.command != CMD_TICK) begin
            op_kind  = it.command;
            slot_idx = '0;
            if (it.command == CMD_RESET) begin
                pres_seen = 1'b0;
                enter(PH_RLOW);
            end else begin
                rx_shift = (it.command == CMD_BIT) ? {7'd0, it.tx_byte[0]} : it.tx_byte;
                begin_slot();
            end
        end
        unique case (seq_phase)
            PH_RLOW: begin
                tick_res.drive_low = 1'b1;
                if (count_done(timing.reset_low_time))
                    enter(timing.presence_settle_time != '0 ? PH_RSET : PH_PLOW);
            end
            PH_RSET: begin
                if (count_done(timing.presence_settle_time))
                    enter(PH_PLOW);
            end
            PH_PLOW: begin
                if (!it.line_level)
                    enter(PH_PHIGH);
                else if (count_done(timing.presence_timeout))
                    finish_reset(1'b0);
            end
            PH_PHIGH: begin
                if (it.line_level)
                    finish_reset(1'b1);
                else if (count_done(timing.presence_timeout))
                    finish_reset(1'b0);
            end
            PH_SLOW: begin
                tick_res.drive_low = 1'b1;
                if (count_done(timing.slot_low_time))
                    enter(timing.sample_delay != '0 ? PH_SDLY : PH_SAMP);
            end
            PH_SDLY: begin
                tick_res.drive_low = ~tx_bit;
                if (count_done(timing.sample_delay))
                    enter(PH_SAMP);
            end
            PH_SAMP: begin
                tick_res.drive_low = ~tx_bit;
                rx_shift = {it.line_level, rx_shift[7:1]};
                if (timing.slot_rest_time != '0)
                    enter(PH_REST);
                else
                    after_rest();
            end
            PH_REST: begin
                tick_res.drive_low = ~tx_bit;
                if (count_done(timing.slot_rest_time))
                    after_rest();
            end
            PH_RECV: begin
                if (count_done(timing.recovery_time))
                    close_slot();
            end
            default: begin
                seq_phase = PH_IDLE;
            end
        endcase
        tick_res.busy_res = (seq_phase != PH_IDLE);
        return tick_res;
    endfunction

    function automatic logic [REG_W-1:0] timing_of(int unsigned idx);
        unique case (idx)
            REG_RLOW:   return timing.reset_low_time;
            REG_SETTLE: return timing.presence_settle_time;
            REG_TMO:    return timing.presence_timeout;
            REG_SLOW:   return timing.slot_low_time;
            REG_SDLY:   return timing.sample_delay;
            REG_REST:   return timing.slot_rest_time;
            REG_RECV:   return timing.recovery_time;
            default:    return '0;
        endcase
    endfunction

    function automatic void set_timing(int unsigned idx, logic [REG_W-1:0] v);
        unique case (idx)
            REG_RLOW:   timing.reset_low_time       = v;
            REG_SETTLE: timing.presence_settle_time = v;
            REG_TMO:    timing.presence_timeout     = v;
            REG_SLOW:   timing.slot_low_time        = v;
            REG_SDLY:   timing.sample_delay         = v;
            REG_REST:   timing.slot_rest_time       = v;
            REG_RECV:   timing.recovery_time        = v;
            default:    ;
        endcase
    endfunction

    function automatic t_in make_item(logic [1:0] cmd, logic [7:0] tx, logic line);
        t_in it;
        it.command    = cmd;
        it.tx_byte    = tx;
        it.line_level = line;
        return it;
    endfunction

    function automatic t_in pick_item();
        t_in it;
        it.tx_byte    = 8'($urandom);
        it.line_level = ($urandom_range(0, 2) != 0);
        if (seq_phase == PH_IDLE)
            it.command = ($urandom_range(0, 4) == 0) ? CMD_TICK
                         : 2'($urandom_range(CMD_RESET, CMD_BYTE));
        else
            it.command = ($urandom_range(0, 7) == 0)
                         ? 2'($urandom_range(CMD_RESET, CMD_BYTE)) : CMD_TICK;
        return it;
    endfunction

    function automatic logic [REG_W-1:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return REG_W'($urandom_range(0, 4));
        return REG_W'($urandom_range(5, 40));
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                      results_seen, name, got, want));
    endtask

    task automatic write_reg(int unsigned idx, logic [REG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        set_timing(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(int unsigned idx);
        logic [DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        if (got !== DATA_W'(timing_of(idx)))
            report_mismatch($sformatf("register %0d read %0h expected %0h",
                                      idx, got, timing_of(idx)));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_timing(t_cfg c);
        write_reg(REG_RLOW,   c.reset_low_time);
        write_reg(REG_SETTLE, c.presence_settle_time);
        write_reg(REG_TMO,    c.presence_timeout);
        write_reg(REG_SLOW,   c.slot_low_time);
        write_reg(REG_SDLY,   c.sample_delay);
        write_reg(REG_REST,   c.slot_rest_time);
        write_reg(REG_RECV,   c.recovery_time);
    endtask

    task automatic send_tick(t_in it);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(bus_tick(it));
    endtask

    task automatic run_until_idle();
        do send_tick(pick_item()); while (seq_phase != PH_IDLE);
    endtask

    // hold off new transactions until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_register_access();
        for (int unsigned i = 0; i < NUM_REGS; i++)
            check_reg(i);
        for (int unsigned i = 0; i < NUM_REGS; i++) begin
            write_reg(i, '1);
            check_reg(i);
            write_reg(i, '0);
            check_reg(i);
        end
        write_reg(UNUSED_REG, '1);
        for (int unsigned i = 0; i < NUM_REGS; i++)
            check_reg(i);
    endtask

    task automatic test_reset_presence();
        t_cfg c;
        drain();
        c = '0;
        c.reset_low_time   = 10'd1;
        c.presence_timeout = 10'd2;
        c.slot_low_time    = 10'd1;
        load_timing(c);
        send_tick(make_item(CMD_RESET, 8'h00, 1'b1));
        send_tick(make_item(CMD_TICK, 8'hFF, 1'b0));
        send_tick(make_item(CMD_TICK, 8'h00, 1'b1));
        send_tick(make_item(CMD_RESET, 8'hFF, 1'b1));
        send_tick(make_item(CMD_TICK, 8'h00, 1'b1));
        send_tick(make_item(CMD_TICK, 8'h00, 1'b1));
        send_tick(make_item(CMD_RESET, 8'h00, 1'b0));
        repeat (3) send_tick(make_item(CMD_TICK, 8'h00, 1'b0));
    endtask

    task automatic test_bit_slots();
        send_tick(make_item(CMD_BIT, 8'h01, 1'b0));
        send_tick(make_item(CMD_TICK, 8'h00, 1'b1));
        send_tick(make_item(CMD_BIT, 8'hFE, 1'b1));
        send_tick(make_item(CMD_TICK, 8'h00, 1'b0));
    endtask

    task automatic test_byte_with_busy_starts();
        logic [1:0] busy_cmds [4] = '{CMD_RESET, CMD_BIT, CMD_BYTE, CMD_TICK};
        send_tick(make_item(CMD_BYTE, 8'hA5, 1'b0));
        for (int k = 0; k < 15; k++)
            send_tick(make_item(busy_cmds[k % 4], 8'h5A, k[1]));
        run_until_idle();
    endtask

    task automatic test_live_register_write();
        t_cfg c;
        drain();
        c = timing;
        c.slot_low_time  = 10'd1;
        c.sample_delay   = 10'd2;
        c.slot_rest_time = 10'd20;
        c.recovery_time  = 10'd2;
        load_timing(c);
        send_tick(make_item(CMD_BIT, 8'h01, 1'b1));
        while (!(seq_phase == PH_REST && us_count >= 10))
            send_tick(make_item(CMD_TICK, 8'($urandom), 1'($urandom)));
        drain();
        write_reg(REG_REST, 10'd3);
        run_until_idle();
    endtask

    task automatic test_extreme_timing();
        t_cfg c;
        drain();
        gaps_on = 1'b0;
        load_timing('1);
        send_tick(make_item(CMD_BIT, 8'($urandom), 1'b1));
        repeat (12) send_tick(make_item(CMD_TICK, 8'($urandom), 1'b1));
        drain();
        c = '0;
        c.slot_low_time = 10'd4;
        load_timing(c);
        run_until_idle();
        drain();
        load_timing('1);
        send_tick(make_item(CMD_RESET, 8'($urandom), 1'b1));
        repeat (12) send_tick(make_item(CMD_TICK, 8'($urandom), 1'b1));
        drain();
        c.reset_low_time = 10'd4;
        load_timing(c);
        while (seq_phase != PH_IDLE)
            send_tick(make_item(CMD_TICK, 8'($urandom), 1'b1));
        drain();
        gaps_on = 1'b1;
        load_timing('0);
        send_tick(make_item(CMD_RESET, 8'h00, 1'b1));
        run_until_idle();
        send_tick(make_item(CMD_BIT, 8'h00, 1'b0));
        run_until_idle();
        send_tick(make_item(CMD_BYTE, 8'($urandom), 1'b1));
        run_until_idle();
    endtask

    task automatic test_random_traffic();
        t_cfg c;
        for (int p = 0; p < 6; p++) begin
            drain();
            c.reset_low_time       = pick_duration();
            c.presence_settle_time = pick_duration();
            c.presence_timeout     = pick_duration();
            c.slot_low_time        = pick_duration();
            c.sample_delay         = pick_duration();
            c.slot_rest_time       = pick_duration();
            c.recovery_time        = pick_duration();
            load_timing(c);
            gaps_on = ($urandom_range(0, 2) != 0);
            repeat (80) send_tick(pick_item());
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no transaction pending: %h",
                                          o_out_data));
            end else begin
                want = pending_results.pop_front();
                check_field("drive_low", 8'(o_out_data.drive_low), 8'(want.drive_low));
                check_field("busy_res",  8'(o_out_data.busy_res),  8'(want.busy_res));
                check_field("done_res",  8'(o_out_data.done_res),  8'(want.done_res));
                check_field("presence",  8'(o_out_data.presence),  8'(want.presence));
                check_field("rx_byte",   o_out_data.rx_byte,       want.rx_byte);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_pct  = 25 * $urandom_range(0, 3);
            stall_left = $urandom_range(16, 128);
        end else begin
            stall_left--;
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        seq_phase   = PH_IDLE;
        op_kind     = CMD_TICK;
        us_count    = '0;
        slot_idx    = '0;
        rx_shift    = '0;
        pres_seen   = 1'b0;
        tx_bit      = 1'b0;
        timing      = '{RST_RLOW, RST_SETTLE, RST_TMO, RST_SLOW, RST_SDLY, RST_REST, RST_RECV};
        err_count   = 0;
        results_seen = 0;
        cycles      = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        stall_pct   = 0;
        stall_left  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_reset_presence();
        test_bit_slots();
        test_byte_with_busy_starts();
        test_live_register_write();
        test_extreme_timing();
        test_random_traffic();
        drain();
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/owb_pkg.sv
hdl/owb_cfg.sv
hdl/owb_core.sv
hdl/one_wire_bus_master_unit.sv
test/tb_one_wire_bus_master_unit.sv
